/* sv/lmcd_pkg.sv */
package lmcd_pkg;

   localparam int MAX_DEVICES_DEF = 8;
   localparam int ROWS = 8;
   localparam int ROW_W = 3;
   localparam int COUNT_W = 4;

   localparam logic [3:0] REG_NOOP = 4'd0;
   localparam logic [3:0] REG_INTENSITY = 4'd10;
   localparam logic [3:0] REG_SCANLIMIT = 4'd11;
   localparam logic [3:0] REG_SHUTDOWN = 4'd12;
   localparam logic [7:0] LEFT_BIT = 8'h80;
   localparam logic [7:0] SCAN_LIMIT_MAX = 8'd7;
   localparam logic [7:0] INTENSITY_MAX = 8'd15;

   typedef enum logic [2:0] {
      OP_SET_LED    = 3'd0,
      OP_SET_ROW    = 3'd1,
      OP_SET_COLUMN = 3'd2,
      OP_CLEAR      = 3'd3,
      OP_POWER_DOWN = 3'd4,
      OP_SCAN_LIMIT = 3'd5,
      OP_BRIGHTNESS = 3'd6,
      OP_UNUSED     = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      UPC_IDLE,
      UPC_LED_RD,
      UPC_LED_MOD,
      UPC_SET_ROW,
      UPC_CLEAR,
      UPC_CTRL,
      UPC_FRAME
   } upc_type;

   typedef enum logic [1:0] {
      DSEL_MODIFY,
      DSEL_VALUE,
      DSEL_ZERO,
      DSEL_CTRL
   } dsel_type;

   typedef enum logic [1:0] {
      NXT_DISPATCH,
      NXT_GO,
      NXT_FRAME_LOOP
   } nxt_type;

   typedef struct packed {
      logic     rd_en;
      logic     wr_en;
      logic     load_data;
      dsel_type dsel;
      nxt_type  nxt;
      upc_type  target;
   } uword_type;

   function automatic uword_type ucode_rom(input upc_type step);
      uword_type uw;
      uw = '{rd_en: 1'b0, wr_en: 1'b0, load_data: 1'b0, dsel: DSEL_ZERO,
             nxt: NXT_DISPATCH, target: UPC_IDLE};
      unique case (step)
         UPC_IDLE: begin
            uw.nxt = NXT_DISPATCH;
         end
         UPC_LED_RD: begin
            uw.rd_en = 1'b1;
            uw.nxt = NXT_GO;
            uw.target = UPC_LED_MOD;
         end
         UPC_LED_MOD: begin
            uw.wr_en = 1'b1;
            uw.load_data = 1'b1;
            uw.dsel = DSEL_MODIFY;
            uw.nxt = NXT_GO;
            uw.target = UPC_FRAME;
         end
         UPC_SET_ROW: begin
            uw.wr_en = 1'b1;
            uw.load_data = 1'b1;
            uw.dsel = DSEL_VALUE;
            uw.nxt = NXT_GO;
            uw.target = UPC_FRAME;
         end
         UPC_CLEAR: begin
            uw.wr_en = 1'b1;
            uw.load_data = 1'b1;
            uw.dsel = DSEL_ZERO;
            uw.nxt = NXT_GO;
            uw.target = UPC_FRAME;
         end
         UPC_CTRL: begin
            uw.load_data = 1'b1;
            uw.dsel = DSEL_CTRL;
            uw.nxt = NXT_GO;
            uw.target = UPC_FRAME;
         end
         UPC_FRAME: begin
            uw.nxt = NXT_FRAME_LOOP;
         end
         default: begin
            uw.nxt = NXT_DISPATCH;
         end
      endcase
      return uw;
   endfunction

   function automatic upc_type entry_step(input op_type op);
      upc_type step;
      unique case (op) inside
         OP_SET_LED, OP_SET_COLUMN:                  step = UPC_LED_RD;
         OP_SET_ROW:                                 step = UPC_SET_ROW;
         OP_CLEAR:                                   step = UPC_CLEAR;
         OP_POWER_DOWN, OP_SCAN_LIMIT, OP_BRIGHTNESS: step = UPC_CTRL;
         default:                                    step = UPC_IDLE;
      endcase
      return step;
   endfunction

endpackage

/* sv/lmcd_if.sv */
interface lmcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] opcode;
   logic [2:0] device;
   logic [2:0] row;
   logic [2:0] column;
   logic [7:0] value;
   logic       led_on;

   modport source (output valid, opcode, device, row, column, value, led_on, input ready);
   modport sink (input valid, opcode, device, row, column, value, led_on, output ready);
endinterface

interface lmcd_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] reg_addr;
   logic [7:0] reg_data;
   logic       frame_end;
   logic       last;

   modport source (output valid, reg_addr, reg_data, frame_end, last, input ready);
   modport sink (input valid, reg_addr, reg_data, frame_end, last, output ready);
endinterface

interface lmcd_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] device_count;

   modport source (output valid, device_count, input ready);
   modport sink (input valid, device_count, output ready);
endinterface

/* sv/lmcd_ram.sv */
module lmcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

/* sv/led_matrix_cascade_frame_driver.sv */
// A command is dispatched from idle; for each frame the data is then formed (after a read of
// the row shadow for set LED and set column) and one word is emitted per chip in the chain,
// holding while the response output stalls. Set row, set LED and control commands form one
// frame; set column and clear form one frame per row. Ignored commands return to idle.
// Reset is synchronous: the row shadow reads as zero through per-entry valid flags, so
// there is no clearing pass, and the chain length returns to eight.
module led_matrix_cascade_frame_driver
   import lmcd_pkg::*;
#(
   parameter int MAX_DEVICES = MAX_DEVICES_DEF
) (
   input logic      clock,
   input logic      reset,
   lmcd_req_if.sink   req_if,
   lmcd_rsp_if.source rsp_if,
   lmcd_csr_if.sink   csr_if
);

   localparam int DEPTH = MAX_DEVICES * ROWS;
   localparam int AW = $clog2(DEPTH);
   localparam int CHIP_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_DEVICES);

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] eff_count;

   upc_type            upc_ff, upc_in;
   upc_type            loop_ff, loop_in;
   op_type             op_ff, op_in;
   logic [2:0]         dev_ff, dev_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [2:0]         col_ff, col_in;
   logic [7:0]         value_ff, value_in;
   logic               on_ff, on_in;
   logic               multi_ff, multi_in;
   logic [CHIP_W-1:0]  chip_ff, chip_in;
   logic [3:0]         reg_ff, reg_in;
   logic [7:0]         data_ff, data_in;
   logic [DEPTH-1:0]   valid_ff, valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [3:0]         rsp_addr_ff, rsp_addr_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_fe_ff, rsp_fe_in;
   logic               rsp_last_ff, rsp_last_in;

   uword_type          uw;
   logic [AW-1:0]      addr;
   logic [7:0]         rd_data;
   logic [7:0]         cur_row;
   logic [7:0]         mask;
   logic               bit_on;
   logic [7:0]         new_data;
   logic [3:0]         new_reg;
   logic               accept;
   logic               ignore;
   op_type             req_op;
   logic               emit;
   logic               frame_done;
   logic               more_rows;
   logic               chip_hit;

   assign eff_count = (count_ff == '0 || count_ff > MAX_COUNT) ? MAX_COUNT : count_ff;
   assign addr = AW'({dev_ff, row_ff});
   assign req_op = op_type'(req_if.opcode);

   lmcd_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_shadow (
      .clock  (clock),
      .wr_en  (uw.wr_en),
      .wr_addr(addr),
      .wr_data(new_data),
      .rd_en  (uw.rd_en),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   // Control word and datapath outputs.
   always_comb begin
      uw = ucode_rom(upc_ff);
      accept = req_if.valid && req_if.ready;
      ignore = (COUNT_W'(req_if.device) >= eff_count) || (req_op == OP_UNUSED) ||
               (req_op == OP_SCAN_LIMIT && req_if.value > SCAN_LIMIT_MAX) ||
               (req_op == OP_BRIGHTNESS && req_if.value > INTENSITY_MAX);
      more_rows = multi_ff && (row_ff != ROW_W'(ROWS - 1));
      emit = (upc_ff == UPC_FRAME) && (!rsp_valid_ff || rsp_if.ready);
      frame_done = emit && (chip_ff == '0);
      chip_hit = (COUNT_W'(dev_ff) == COUNT_W'(chip_ff));

      cur_row = valid_ff[addr] ? rd_data : 8'd0;
      mask = LEFT_BIT >> col_ff;
      bit_on = (op_ff == OP_SET_COLUMN) ? value_ff[~row_ff] : on_ff;
      new_reg = 4'(row_ff) + 4'd1;
      new_data = 8'd0;
      case (uw.dsel)
         DSEL_MODIFY: new_data = bit_on ? (cur_row | mask) : (cur_row & ~mask);
         DSEL_VALUE:  new_data = value_ff;
         DSEL_ZERO:   new_data = 8'd0;
         DSEL_CTRL: begin
            case (op_ff)
               OP_POWER_DOWN: begin
                  new_reg = REG_SHUTDOWN;
                  new_data = on_ff ? 8'd0 : 8'd1;
               end
               OP_SCAN_LIMIT: begin
                  new_reg = REG_SCANLIMIT;
                  new_data = value_ff;
               end
               default: begin
                  new_reg = REG_INTENSITY;
                  new_data = value_ff;
               end
            endcase
         end
         default: new_data = 8'd0;
      endcase

      req_if.ready = (upc_ff == UPC_IDLE);
      csr_if.ready = 1'b1;
      rsp_if.valid = rsp_valid_ff;
      rsp_if.reg_addr = rsp_addr_ff;
      rsp_if.reg_data = rsp_data_ff;
      rsp_if.frame_end = rsp_fe_ff;
      rsp_if.last = rsp_last_ff;
   end

   // Step counter, operand and frame registers.
   always_comb begin
      upc_in = upc_ff;
      loop_in = loop_ff;
      op_in = op_ff;
      dev_in = dev_ff;
      row_in = row_ff;
      col_in = col_ff;
      value_in = value_ff;
      on_in = on_ff;
      multi_in = multi_ff;
      chip_in = chip_ff;
      reg_in = reg_ff;
      data_in = data_ff;
      valid_in = valid_ff;
      count_in = count_ff;

      if (csr_if.valid && csr_if.ready) begin
         count_in = csr_if.device_count;
      end

      unique case (uw.nxt)
         NXT_DISPATCH: begin
            if (accept) begin
               op_in = req_op;
               dev_in = req_if.device;
               col_in = req_if.column;
               value_in = req_if.value;
               on_in = req_if.led_on;
               multi_in = (req_op == OP_SET_COLUMN) || (req_op == OP_CLEAR);
               row_in = ((req_op == OP_SET_COLUMN) || (req_op == OP_CLEAR)) ? '0 : req_if.row;
               loop_in = entry_step(req_op);
               upc_in = ignore ? UPC_IDLE : entry_step(req_op);
            end
         end
         NXT_GO: begin
            upc_in = uw.target;
         end
         NXT_FRAME_LOOP: begin
            if (frame_done) begin
               if (more_rows) begin
                  row_in = row_ff + ROW_W'(1);
                  upc_in = loop_ff;
               end else begin
                  upc_in = UPC_IDLE;
               end
            end
         end
         default: begin
            upc_in = UPC_IDLE;
         end
      endcase

      if (uw.load_data) begin
         data_in = new_data;
         reg_in = new_reg;
         chip_in = CHIP_W'(eff_count - COUNT_W'(1));
      end
      if (uw.wr_en) begin
         valid_in[addr] = 1'b1;
      end
      if (emit && chip_ff != '0) begin
         chip_in = chip_ff - CHIP_W'(1);
      end
   end

   // Output word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_addr_in = rsp_addr_ff;
      rsp_data_in = rsp_data_ff;
      rsp_fe_in = rsp_fe_ff;
      rsp_last_in = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_addr_in = chip_hit ? reg_ff : REG_NOOP;
         rsp_data_in = chip_hit ? data_ff : 8'd0;
         rsp_fe_in = (chip_ff == '0);
         rsp_last_in = (chip_ff == '0) && !more_rows;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
         loop_ff <= UPC_IDLE;
         valid_ff <= '0;
         count_ff <= COUNT_W'(MAX_DEVICES_DEF);
         rsp_valid_ff <= 1'b0;
         chip_ff <= '0;
         multi_ff <= 1'b0;
      end else begin
         upc_ff <= upc_in;
         loop_ff <= loop_in;
         valid_ff <= valid_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         chip_ff <= chip_in;
         multi_ff <= multi_in;
      end
      op_ff <= op_in;
      dev_ff <= dev_in;
      row_ff <= row_in;
      col_ff <= col_in;
      value_ff <= value_in;
      on_ff <= on_in;
      reg_ff <= reg_in;
      data_ff <= data_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fe_ff <= rsp_fe_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_shadow_write_in_chain: assert property (
      @(posedge clock) disable iff (reset)
      uw.wr_en |-> (COUNT_W'(dev_ff) < eff_count))
      else $error("Row shadow written for a device outside the chain.");

   a_chip_in_chain: assert property (
      @(posedge clock) disable iff (reset)
      (upc_ff == UPC_FRAME) |-> (COUNT_W'(chip_ff) < eff_count))
      else $error("Frame word issued for a chip outside the chain.");

   a_row_advance: assert property (
      @(posedge clock) disable iff (reset)
      (frame_done && more_rows) |=> (row_ff == $past(row_ff) + ROW_W'(1)))
      else $error("Row counter did not advance after a frame.");

endmodule
